@@ hw/rtl/ssq_pkg.sv @@
// Shared types, constants and helpers of the sorted start-time queue.
`timescale 1ns / 1ps

package ssq_pkg;

  // Capacity of the queue, the widths that follow from it and the entry field widths.
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ID_W    = 16;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned ENTRY_W = ID_W + KEY_W;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DEQ_CMP,
    S_RESP
  } ctrl_state_e;

  // One request to the entry memory.
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  // One finished result on its way to the output register.
  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  proc_id;
    logic [KEY_W-1:0] start_at;
    logic [OCC_W-1:0] occupancy;
  } res_t;

  // Physical address of a queue position, counted from the head, with wrap.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                   input logic [ADDR_W-1:0] lidx);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, lidx};
    if (sum >= (ADDR_W + 1)'(DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

@@ hw/rtl/ssq_if.sv @@
// Valid/ready channel interfaces for the queue's command and result items.
`timescale 1ns / 1ps

interface ssq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [ssq_pkg::ID_W-1:0]    proc_id;
  logic [ssq_pkg::KEY_W-1:0]   start_at;

  modport source (output valid, command, proc_id, start_at, input ready);
  modport sink   (input valid, command, proc_id, start_at, output ready);
endinterface

interface ssq_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [ssq_pkg::ID_W-1:0]    out_proc_id;
  logic [ssq_pkg::KEY_W-1:0]   out_start_at;
  logic [ssq_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, status, out_proc_id, out_start_at, occupancy,
                  input ready);
  modport sink   (input valid, status, out_proc_id, out_start_at, occupancy,
                  output ready);
endinterface

@@ hw/rtl/ssq_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ssq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ssq_ctrl.sv @@
// Queue controller: head and count registers and the insert/dequeue sequencer.
`timescale 1ns / 1ps

module ssq_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ssq_in_if.sink                         in_i,
  output ssq_pkg::mem_req_t              mem_req_o,
  input  logic [ssq_pkg::ENTRY_W-1:0]    mem_rdata_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output ssq_pkg::res_t                  res_o
);

  ssq_pkg::ctrl_state_e             state_q, state_d;
  logic [ssq_pkg::ADDR_W-1:0]       head_q, head_d;
  logic [ssq_pkg::CNT_W-1:0]        count_q, count_d;
  logic [ssq_pkg::ADDR_W-1:0]       pos_q, pos_d;
  logic [ssq_pkg::ENTRY_W-1:0]      new_q, new_d;
  ssq_pkg::status_e                 status_q, status_d;
  logic [ssq_pkg::ENTRY_W-1:0]      deq_q, deq_d;
  logic                             in_acc;
  logic                             is_full;
  logic                             is_empty;
  logic                             goes_before;

  assign in_acc      = in_i.valid && in_i.ready;
  assign is_full     = (count_q == ssq_pkg::CNT_W'(ssq_pkg::DEPTH));
  assign is_empty    = (count_q == '0);
  // The new entry moves ahead of a held one only on a strictly earlier start time.
  assign goes_before = new_q[ssq_pkg::KEY_W-1:0] < mem_rdata_i[ssq_pkg::KEY_W-1:0];

  // Control state and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssq_pkg::S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q    <= new_d;
    status_q <= status_d;
    deq_q    <= deq_d;
  end

  // Next state, memory requests and result bookkeeping.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    pos_d     = pos_q;
    new_d     = new_q;
    status_d  = status_q;
    deq_d     = deq_q;
    mem_req_o = '0;
    in_i.ready  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ssq_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_acc) begin
          status_d = ssq_pkg::ST_OK;
          deq_d    = '0;
          if (in_i.command == ssq_pkg::CMD_INSERT) begin
            new_d = {in_i.proc_id, in_i.start_at};
            pos_d = count_q[ssq_pkg::ADDR_W-1:0];
            if (is_full) begin
              status_d = ssq_pkg::ST_FULL;
              state_d  = ssq_pkg::S_RESP;
            end else begin
              state_d = ssq_pkg::S_INS_RD;
            end
          end else begin
            if (is_empty) begin
              status_d = ssq_pkg::ST_EMPTY;
              state_d  = ssq_pkg::S_RESP;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = head_q;
              state_d         = ssq_pkg::S_DEQ_CMP;
            end
          end
        end
      end

      // Either place the new entry at the head or fetch its predecessor.
      ssq_pkg::S_INS_RD: begin
        if (pos_q == '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = head_q;
          mem_req_o.wdata = new_q;
          count_d         = count_q + 1'b1;
          state_d         = ssq_pkg::S_RESP;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ssq_pkg::phys_addr(head_q, pos_q - 1'b1);
          state_d         = ssq_pkg::S_INS_CMP;
        end
      end

      // Shift the predecessor up one place, or settle the new entry here.
      ssq_pkg::S_INS_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ssq_pkg::phys_addr(head_q, pos_q);
        if (goes_before) begin
          mem_req_o.wdata = mem_rdata_i;
          pos_d           = pos_q - 1'b1;
          state_d         = ssq_pkg::S_INS_RD;
        end else begin
          mem_req_o.wdata = new_q;
          count_d         = count_q + 1'b1;
          state_d         = ssq_pkg::S_RESP;
        end
      end

      // The head entry is back from memory: pop it.
      ssq_pkg::S_DEQ_CMP: begin
        deq_d   = mem_rdata_i;
        head_d  = ssq_pkg::phys_addr(head_q, ssq_pkg::ADDR_W'(1));
        count_d = count_q - 1'b1;
        state_d = ssq_pkg::S_RESP;
      end

      ssq_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ssq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ssq_pkg::S_IDLE;
      end
    endcase
  end

  // The count is already updated when the result is offered.
  assign res_o.status    = status_q;
  assign res_o.proc_id   = deq_q[ssq_pkg::ENTRY_W-1:ssq_pkg::KEY_W];
  assign res_o.start_at  = deq_q[ssq_pkg::KEY_W-1:0];
  assign res_o.occupancy = ssq_pkg::OCC_W'(count_q);

endmodule

@@ hw/rtl/sorted_start_time_queue.sv @@
// Sorted start-time queue: top level with entry memory, controller and output register.
//
// A bounded priority queue of (process id, start time) entries kept in ascending
// order of start time; ties leave in arrival order. Commands arrive on in_i
// (valid/ready): an insert places proc_id/start_at behind every held entry with
// an equal or earlier start time, a dequeue pops the head. Every command gives
// exactly one result item on out_o with a status (ok, dequeue while empty,
// insert while full), the popped id and start time (zero otherwise) and the
// occupancy after the command. Failed commands leave the queue unchanged.
// The entries live in one RAM used as a ring from a head pointer, so a dequeue
// only moves the head. An insert walks from the tail towards the head, one
// read and one write-back per displaced entry through the single read port.
// One command is in work at a time. The result sits in an output register, so
// the next command is taken while an earlier result still waits; a stalled
// receiver holds the controller only once a second result is ready.
// Reset empties the queue at once; no memory clearing pass is needed.

`timescale 1ns / 1ps

module sorted_start_time_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssq_in_if.sink      in_i,
  ssq_out_if.source   out_o
);

  ssq_pkg::mem_req_t               mem_req;
  logic [ssq_pkg::ENTRY_W-1:0]     mem_rdata;
  logic                            res_valid;
  logic                            res_ready;
  ssq_pkg::res_t                   res;
  logic                            out_valid_q, out_valid_d;
  ssq_pkg::res_t                   out_q, out_d;

  // Entry store.
  ssq_ram #(
    .WIDTH (ssq_pkg::ENTRY_W),
    .DEPTH (ssq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer.
  ssq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads when empty or being drained.
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.out_proc_id  = out_q.proc_id;
  assign out_o.out_start_at = out_q.start_at;
  assign out_o.occupancy    = out_q.occupancy;

  // A rejected insert can only come from a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == ssq_pkg::ST_FULL)
    |-> out_o.occupancy == ssq_pkg::OCC_W'(ssq_pkg::DEPTH))
    else $error("full status with occupancy below capacity");

  // A rejected dequeue comes from an empty queue and carries no entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == ssq_pkg::ST_EMPTY)
    |-> (out_o.occupancy == '0) && (out_o.out_proc_id == '0)
        && (out_o.out_start_at == '0))
    else $error("empty status with entries held or data returned");

  // One command at a time: after an accepted item the controller is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second item accepted while the first is in work");

  // A result that cannot be handed over is held and not dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result lost or changed");

endmodule

@@ bench/sorted_start_time_queue_test.sv @@
// Self-checking testbench for the sorted start-time queue.
`timescale 1ns / 1ps

module sorted_start_time_queue_test;
  import ssq_pkg::*;

  localparam int unsigned DIRECTED_ROWS = 25;
  localparam int unsigned RANDOM_PER_PHASE = 275;
  localparam int unsigned PHASES = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // One held entry of the predicted queue.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } slot_t;

  // One row of the directed stimulus; want is used only where typed is set.
  typedef struct packed {
    cmd_e             cmd;
    logic [ID_W-1:0]  pid;
    logic [KEY_W-1:0] key;
    logic             typed;
    res_t             want;
  } plan_row_t;

  localparam res_t UNTYPED = '{ST_OK, 16'h0, 16'h0, 5'd0};

  logic clk_i;
  logic rst_ni;

  ssq_in_if  cmd_bus ();
  ssq_out_if res_bus ();

  sorted_start_time_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_bus),
    .out_o  (res_bus)
  );

  slot_t       held_entries[$];
  res_t        expected_results[$];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  int unsigned cycles;

  // Directed items: empty dequeue, field extremes, head replacement, ties and a full queue.
  plan_row_t directed_plan [DIRECTED_ROWS] = '{
    '{CMD_DEQUEUE, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 5'd0}},
    '{CMD_INSERT,  16'hFFFF, 16'hFFFF, 1'b1, '{ST_OK, 16'h0, 16'h0, 5'd1}},
    '{CMD_INSERT,  16'h0000, 16'h0000, 1'b1, '{ST_OK, 16'h0, 16'h0, 5'd2}},
    '{CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b1, '{ST_OK, 16'h0, 16'h0, 5'd1}},
    '{CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b1, '{ST_OK, 16'hFFFF, 16'hFFFF, 5'd0}},
    '{CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 5'd0}},
    '{CMD_INSERT,  16'h0001, 16'd300,  1'b0, UNTYPED},
    '{CMD_INSERT,  16'h0002, 16'd200,  1'b0, UNTYPED},
    '{CMD_INSERT,  16'h0003, 16'd200,  1'b0, UNTYPED},
    '{CMD_INSERT,  16'h0004, 16'd100,  1'b0, UNTYPED},
    '{CMD_INSERT,  16'hAAAA, 16'hFFFF, 1'b0, UNTYPED},
    '{CMD_INSERT,  16'h5555, 16'h0000, 1'b0, UNTYPED},
    '{CMD_INSERT,  16'h0007, 16'd200,  1'b0, UNTYPED},
    '{CMD_INSERT,  16'h0008, 16'd50,   1'b0, UNTYPED},
    '{CMD_INSERT,  16'h0009, 16'd300,  1'b0, UNTYPED},
    '{CMD_INSERT,  16'h000A, 16'd1,    1'b0, UNTYPED},
    '{CMD_INSERT,  16'h8000, 16'hFFFE, 1'b0, UNTYPED},
    '{CMD_INSERT,  16'h000C, 16'd200,  1'b0, UNTYPED},
    '{CMD_INSERT,  16'h000D, 16'd7,    1'b0, UNTYPED},
    '{CMD_INSERT,  16'h000E, 16'd7,    1'b0, UNTYPED},
    '{CMD_INSERT,  16'h7FFF, 16'h0000, 1'b0, UNTYPED},
    '{CMD_INSERT,  16'h0010, 16'd150,  1'b0, UNTYPED},
    '{CMD_INSERT,  16'h1234, 16'hABCD, 1'b1, '{ST_FULL, 16'h0, 16'h0, 5'd16}},
    '{CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b0, UNTYPED},
    '{CMD_INSERT,  16'h8001, 16'h0000, 1'b0, UNTYPED}
  };

  // Works out the result of one command and updates the predicted queue.
  function automatic res_t predict_outcome(input cmd_e cmd, input logic [ID_W-1:0] pid,
                                           input logic [KEY_W-1:0] key);
    res_t  r;
    slot_t s;
    int    pos;
    r = UNTYPED;
    if (cmd == CMD_INSERT) begin
      if (held_entries.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // The new entry goes behind every entry with an equal or earlier start time.
        pos = held_entries.size();
        for (int i = 0; i < held_entries.size(); i++) begin
          if (key < held_entries[i].key) begin
            pos = i;
            break;
          end
        end
        s.id  = pid;
        s.key = key;
        held_entries.insert(pos, s);
      end
    end else if (held_entries.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      s = held_entries.pop_front();
      r.proc_id  = s.id;
      r.start_at = s.key;
    end
    r.occupancy = OCC_W'(held_entries.size());
    return r;
  endfunction

  // Clock generation.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Cycle counter with the run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver side: stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result: none expected, got status %0d id %0h start %0h occupancy %0d",
               res_bus.status, res_bus.out_proc_id, res_bus.out_start_at,
               res_bus.occupancy);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (res_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_bus.status);
          mismatches++;
        end
        if (res_bus.out_proc_id !== want.proc_id) begin
          $error("out_proc_id: expected %0h, got %0h", want.proc_id, res_bus.out_proc_id);
          mismatches++;
        end
        if (res_bus.out_start_at !== want.start_at) begin
          $error("out_start_at: expected %0h, got %0h", want.start_at,
                 res_bus.out_start_at);
          mismatches++;
        end
        if (res_bus.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, res_bus.occupancy);
          mismatches++;
        end
      end
    end
  end

  // Offers one item, waits for it to be taken and records what should come back.
  task automatic send_command(input cmd_e cmd, input logic [ID_W-1:0] pid,
                              input logic [KEY_W-1:0] key, input logic typed,
                              input res_t want);
    res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.command  <= cmd;
    cmd_bus.proc_id  <= pid;
    cmd_bus.start_at <= key;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    predicted = predict_outcome(cmd, pid, key);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic wait_for_results();
    cmd_bus.valid <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
  endtask

  // Draws one random command; ins_pct biases towards filling or draining.
  task automatic random_command(input int unsigned ins_pct);
    cmd_e             cmd;
    logic [ID_W-1:0]  pid;
    logic [KEY_W-1:0] key;
    cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DEQUEUE;
    pid = ID_W'($urandom);
    case ($urandom_range(0, 9))
      0: key = '0;
      1: key = '1;
      2, 3, 4, 5: key = KEY_W'($urandom_range(0, 7));
      default: key = KEY_W'($urandom);
    endcase
    send_command(cmd, pid, key, 1'b0, UNTYPED);
  endtask

  // Main sequence: reset, directed table, then random phases with different idling.
  initial begin : stimulus
    int unsigned ins_pct;
    rst_ni           = 1'b0;
    cmd_bus.valid    = 1'b0;
    cmd_bus.command  = CMD_INSERT;
    cmd_bus.proc_id  = '0;
    cmd_bus.start_at = '0;
    res_bus.ready    = 1'b0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    mismatches       = 0;
    cycles           = 0;
    ins_pct          = 50;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_command(directed_plan[r].cmd, directed_plan[r].pid, directed_plan[r].key,
                   directed_plan[r].typed, directed_plan[r].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      // Each phase starts from a quiet block.
      wait_for_results();
      case (p)
        1: begin
          send_idle_pct = 86;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 86;
        end
        3: begin
          send_idle_pct = 17;
          stall_pct     = 17;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      @(posedge clk_i);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Switch between filling, draining and mixed stretches.
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: ins_pct = 85;
            1: ins_pct = 15;
            default: ins_pct = 50;
          endcase
        end
        random_command(ins_pct);
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
